[sv/rgb_to_hsv_conversion_unit_assert.svh]
// ----------------------------------------------------------------------------
// rgb to hsv conversion unit assertion macros
// concurrent assertion helpers shared by the rgb to hsv rtl
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERSION_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERSION_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RGB2HSV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RGB2HSV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/rgb2hsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgb2hsv package
// types and constants shared by the rgb to hsv conversion unit
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

   localparam int CHAN_W = 8;
   localparam int HUE_W  = 15;

   // divider sizing: quotient bits, remainder, divisor and pre-shifted divisor
   localparam int QUO_W     = 12;
   localparam int REM_W     = 21;
   localparam int DEN_W     = 9;
   localparam int DSH_W     = DEN_W + QUO_W - 1;
   localparam int NUM_CELLS = QUO_W;

   // hue scale doubled for round to nearest, saturation scale doubled likewise
   localparam int HUE_SCALE2 = 7680;
   localparam int SAT_SCALE2 = 510;

   localparam logic [HUE_W-1:0] HUE_FULL     = 15'd23040;
   localparam logic [HUE_W-1:0] GREEN_OFFSET = 15'd7680;
   localparam logic [HUE_W-1:0] BLUE_OFFSET  = 15'd15360;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // one restoring division in flight
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DSH_W-1:0] dsh;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

   // pixel attributes that ride along with the divisions
   typedef struct packed {
      logic              neg;
      sector_type        sector;
      logic              grey;
      logic              black;
      logic [CHAN_W-1:0] brightness;
   } side_type;

endpackage

[sv/rgb2hsv_prep.sv]
// ----------------------------------------------------------------------------
// rgb2hsv prep
// two register stages: max/min and sector, then division operands
// ----------------------------------------------------------------------------
module rgb2hsv_prep
   import rgb2hsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   input  logic [CHAN_W-1:0] red,
   input  logic [CHAN_W-1:0] green,
   input  logic [CHAN_W-1:0] blue,
   output logic              valid_out,
   output div_lane_type      hue_lane,
   output div_lane_type      sat_lane,
   output side_type          side
);

   logic              valid_a_ff;
   logic [CHAN_W-1:0] max_ff, max_in;
   logic [CHAN_W-1:0] min_ff, min_in;
   sector_type        sector_ff, sector_in;
   logic [CHAN_W:0]   diff_ff, diff_in;

   logic              valid_b_ff;
   div_lane_type      hue_lane_ff, hue_lane_in;
   div_lane_type      sat_lane_ff, sat_lane_in;
   side_type          side_ff, side_in;

   logic [CHAN_W-1:0] delta;
   logic [CHAN_W:0]   diff_abs;
   logic [DEN_W-1:0]  den_h;
   logic [DEN_W-1:0]  den_s;

   // stage a: extremes, sector with ties to red then green
   always_comb begin
      max_in = red;
      min_in = red;
      if (green > max_in) max_in = green;
      if (blue > max_in)  max_in = blue;
      if (green < min_in) min_in = green;
      if (blue < min_in)  min_in = blue;
      if (max_in == red) begin
         sector_in = SECTOR_RED;
         diff_in   = {1'b0, green} - {1'b0, blue};
      end else if (max_in == green) begin
         sector_in = SECTOR_GREEN;
         diff_in   = {1'b0, blue} - {1'b0, red};
      end else begin
         sector_in = SECTOR_BLUE;
         diff_in   = {1'b0, red} - {1'b0, green};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_in;
      end
      max_ff    <= max_in;
      min_ff    <= min_in;
      sector_ff <= sector_in;
      diff_ff   <= diff_in;
   end

   // stage b: numerators and pre-shifted divisors
   always_comb begin
      delta    = max_ff - min_ff;
      diff_abs = diff_ff[CHAN_W] ? ((CHAN_W+1)'(0) - diff_ff) : diff_ff;
      den_h    = {delta, 1'b0};
      den_s    = {max_ff, 1'b0};

      hue_lane_in.rem = REM_W'(diff_abs[CHAN_W-1:0]) * REM_W'(HUE_SCALE2) + REM_W'(delta);
      hue_lane_in.dsh = {den_h, (QUO_W-1)'(0)};
      hue_lane_in.quo = '0;

      sat_lane_in.rem = REM_W'(delta) * REM_W'(SAT_SCALE2) + REM_W'(max_ff);
      sat_lane_in.dsh = {den_s, (QUO_W-1)'(0)};
      sat_lane_in.quo = '0;

      side_in.neg        = diff_ff[CHAN_W];
      side_in.sector     = sector_ff;
      side_in.grey       = (delta == '0);
      side_in.black      = (max_ff == '0);
      side_in.brightness = max_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      hue_lane_ff <= hue_lane_in;
      sat_lane_ff <= sat_lane_in;
      side_ff     <= side_in;
   end

   assign valid_out = valid_b_ff;
   assign hue_lane  = hue_lane_ff;
   assign sat_lane  = sat_lane_ff;
   assign side      = side_ff;

endmodule

[sv/rgb2hsv_div_cell.sv]
// ----------------------------------------------------------------------------
// rgb2hsv div cell
// one restoring division step for hue and saturation, registered
// ----------------------------------------------------------------------------
module rgb2hsv_div_cell
   import rgb2hsv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_in,
   input  div_lane_type hue_in,
   input  div_lane_type sat_in,
   input  side_type     side_in,
   output logic         valid_out,
   output div_lane_type hue_out,
   output div_lane_type sat_out,
   output side_type     side_out
);

   logic         valid_ff;
   div_lane_type hue_ff, hue_nx_in;
   div_lane_type sat_ff, sat_nx_in;
   side_type     side_ff;

   // compare against the shifted divisor, subtract on success, shift one bit in
   function automatic div_lane_type div_step(input div_lane_type x);
      div_lane_type     y;
      logic [REM_W-1:0] dext;
      logic             take;
      dext  = REM_W'(x.dsh);
      take  = (x.rem >= dext);
      y.rem = take ? (x.rem - dext) : x.rem;
      y.dsh = x.dsh >> 1;
      y.quo = {x.quo[QUO_W-2:0], take};
      return y;
   endfunction

   always_comb begin
      hue_nx_in = div_step(hue_in);
      sat_nx_in = div_step(sat_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      hue_ff  <= hue_nx_in;
      sat_ff  <= sat_nx_in;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign hue_out   = hue_ff;
   assign sat_out   = sat_ff;
   assign side_out  = side_ff;

endmodule

[sv/rgb_to_hsv_conversion_unit.sv]
// ----------------------------------------------------------------------------
// rgb to hsv conversion unit
// Converts one 8-bit rgb pixel per clock into hue (1/64 degree units),
// saturation (scaled by 255, rounded) and brightness (largest channel).
// A transaction is taken at every clock edge where start is high; busy is
// always low. Its result appears on the rsp_ ports for one cycle, marked by
// rsp_strobe. Results leave in the order transactions arrived. Each result
// passes through two operand stages, a row of twelve division cells (one
// quotient bit each, hue and saturation side by side) and one output
// register. The receiver cannot stall the unit, so every result must be
// taken in its strobe cycle.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_conversion_unit_assert.svh"

module rgb_to_hsv_conversion_unit
   import rgb2hsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   output logic              rsp_strobe,
   output logic [HUE_W-1:0]  rsp_hue,
   output logic [CHAN_W-1:0] rsp_saturation,
   output logic [CHAN_W-1:0] rsp_brightness
);

   // chain taps: index 0 feeds the first cell, the last index is the row output
   logic         chain_valid [0:NUM_CELLS];
   div_lane_type chain_hue   [0:NUM_CELLS];
   div_lane_type chain_sat   [0:NUM_CELLS];
   side_type     chain_side  [0:NUM_CELLS];

   logic              strobe_ff;
   logic [HUE_W-1:0]  hue_ff, hue_in;
   logic [CHAN_W-1:0] sat_ff, sat_in;
   logic [CHAN_W-1:0] bright_ff;

   logic [HUE_W-1:0]  hue_base;
   logic [HUE_W-1:0]  hue_quo;
   side_type          last_side;

   // the pipeline never stalls, so a transaction is taken whenever start is high
   assign busy = 1'b0;

   // operand preparation: max/min, sector, numerators and divisors
   rgb2hsv_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (start),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .valid_out (chain_valid[0]),
      .hue_lane  (chain_hue[0]),
      .sat_lane  (chain_sat[0]),
      .side      (chain_side[0])
   );

   // row of division cells, msb of the quotient first
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      rgb2hsv_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (chain_valid[i]),
         .hue_in    (chain_hue[i]),
         .sat_in    (chain_sat[i]),
         .side_in   (chain_side[i]),
         .valid_out (chain_valid[i+1]),
         .hue_out   (chain_hue[i+1]),
         .sat_out   (chain_sat[i+1]),
         .side_out  (chain_side[i+1])
      );
   end

   assign last_side = chain_side[NUM_CELLS];

   // sector offset, with a full turn folded in for a negative red hue
   always_comb begin
      hue_quo = HUE_W'(chain_hue[NUM_CELLS].quo);
      case (last_side.sector)
         SECTOR_RED:   hue_base = last_side.neg ? HUE_FULL : '0;
         SECTOR_GREEN: hue_base = GREEN_OFFSET;
         SECTOR_BLUE:  hue_base = BLUE_OFFSET;
         default:      hue_base = '0;
      endcase
      if (last_side.grey) begin
         hue_in = '0;
      end else if (last_side.neg) begin
         hue_in = hue_base - hue_quo;
      end else begin
         hue_in = hue_base + hue_quo;
      end
      // a black pixel divides by zero; its saturation is forced to zero
      sat_in = last_side.black ? '0 : chain_sat[NUM_CELLS].quo[CHAN_W-1:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= chain_valid[NUM_CELLS];
      end
      hue_ff    <= hue_in;
      sat_ff    <= sat_in;
      bright_ff <= last_side.brightness;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;

   // a finished transaction is always presented the next cycle
   `RGB2HSV_ASSERT_NEXT(a_row_to_strobe, clock, reset,
      chain_valid[NUM_CELLS], rsp_strobe, "result dropped")
   // nothing is presented without a finished transaction
   `RGB2HSV_ASSERT_NEXT(a_no_spurious, clock, reset,
      !chain_valid[NUM_CELLS], !rsp_strobe, "spurious result")
   // hue stays below a full turn
   `RGB2HSV_ASSERT_IMPLY(a_hue_range, clock, reset,
      rsp_strobe, rsp_hue < HUE_FULL, "hue out of range")
   // black pixels carry no saturation and no hue
   `RGB2HSV_ASSERT_IMPLY(a_black, clock, reset,
      rsp_strobe && (rsp_brightness == '0),
      (rsp_saturation == '0) && (rsp_hue == '0), "black pixel not cleared")
   // zero saturation only occurs for grey, whose hue is zero
   `RGB2HSV_ASSERT_IMPLY(a_grey_hue, clock, reset,
      rsp_strobe && (rsp_saturation == '0), rsp_hue == '0, "grey pixel with hue")

endmodule
